[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks in the frame builder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, sampled on the rising clock edge, off while in reset
`define LPFB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define LPFB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LPFB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/lpfb_pkg.sv]
// ----------------------------------------------------------------------------
// lpfb_pkg
// Types and constants shared by the frame builder controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lpfb_pkg;

    localparam int          LPFB_MAX_PAYLOAD = 32;
    localparam logic [7:0]  LPFB_HEADER_RST  = 8'h88;

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_HDR,
        ST_FUNC,
        ST_LEN,
        ST_RD,
        ST_PAY,
        ST_SUM
    } t_state;

    typedef enum logic [2:0] {
        SEL_HDR,
        SEL_FUNC,
        SEL_LEN,
        SEL_PAY,
        SEL_SUM
    } t_out_sel;

    typedef struct packed {
        logic     item_accept;
        logic     out_load;
        t_out_sel out_sel;
        logic     rd_issue;
        logic     frame_done;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic pay_more;
    } t_dp_sts;

endpackage

`default_nettype wire

[rtl/lpfb_dp.sv]
// ----------------------------------------------------------------------------
// lpfb_dp
// Frame datapath: payload buffer, length and sum accumulation, header
// register and the output beat register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lpfb_dp import lpfb_pkg::*; #(
    parameter int MAX_PAYLOAD = LPFB_MAX_PAYLOAD
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_valid,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic [7:0] i_payload_byte,
    input  wire logic       i_has_byte,
    input  wire logic [7:0] i_function_code,
    input  wire logic       i_out_stall,
    input  wire t_dp_cmd    i_cmd,
    output t_dp_sts         o_sts,
    output logic            o_out_valid,
    output logic [7:0]      o_tx_byte,
    output logic            o_frame_last
);

    localparam int CW = $clog2(MAX_PAYLOAD + 1);
    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic [7:0]    r_mem [MAX_PAYLOAD];
    logic [7:0]    r_rd_data;
    logic [7:0]    r_header;
    logic [7:0]    r_func;
    logic [7:0]    r_sum;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_rd_idx;
    logic          r_open;
    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic          r_out_last;

    logic          wr_en;
    logic          out_free;
    logic [7:0]    n_out_byte;

    assign wr_en    = i_cmd.item_accept && i_has_byte && (r_count < CW'(MAX_PAYLOAD));
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_sts.out_free = out_free;
    assign o_sts.pay_more = (r_rd_idx != r_count);

    always_comb begin
        unique case (i_cmd.out_sel)
            SEL_HDR:  n_out_byte = r_header;
            SEL_FUNC: n_out_byte = r_func;
            SEL_LEN:  n_out_byte = 8'(r_count);
            SEL_PAY:  n_out_byte = r_rd_data;
            SEL_SUM:  n_out_byte = r_header + r_func + 8'(r_count) + r_sum;
            default:  n_out_byte = r_header;
        endcase
    end

    // payload buffer, one write port and one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_count[AW-1:0]] <= i_payload_byte;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_mem[r_rd_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= LPFB_HEADER_RST;
            r_func   <= 8'd0;
            r_sum    <= 8'd0;
            r_count  <= '0;
            r_rd_idx <= '0;
            r_open   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_header <= i_cfg_data;
            end
            if (i_cmd.item_accept) begin
                r_open <= 1'b1;
                if (!r_open) begin
                    r_func <= i_function_code;
                end
            end
            if (wr_en) begin
                r_count <= r_count + CW'(1);
                r_sum   <= r_sum + i_payload_byte;
            end
            if (i_cmd.rd_issue) begin
                r_rd_idx <= r_rd_idx + CW'(1);
            end
            if (i_cmd.frame_done) begin
                r_open   <= 1'b0;
                r_count  <= '0;
                r_sum    <= 8'd0;
                r_rd_idx <= '0;
            end
        end
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_byte <= n_out_byte;
            r_out_last <= (i_cmd.out_sel == SEL_SUM);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_tx_byte    = r_out_byte;
    assign o_frame_last = r_out_last;

    `LPFB_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(MAX_PAYLOAD), "count past buffer")
    `LPFB_ASSERT(a_rd_behind, i_clk, i_rst_n, r_rd_idx <= r_count, "read index past count")
    `LPFB_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, i_cmd.out_load, out_free, "beat overwritten")
    `LPFB_ASSERT_NXT(a_frame_clear, i_clk, i_rst_n, i_cmd.frame_done,
        (r_count == '0) && !r_open, "frame state not cleared")

endmodule

`default_nettype wire

[rtl/lpfb_ctrl.sv]
// ----------------------------------------------------------------------------
// lpfb_ctrl
// Frame sequencer: collects items, then walks header, function, length,
// payload and checksum beats out through the datapath.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lpfb_ctrl import lpfb_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_payload_last,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd,
    output logic         o_in_stall
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_COLLECT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_COLLECT: if (i_in_valid && i_payload_last) n_state = ST_HDR;
            ST_HDR:     if (i_sts.out_free) n_state = ST_FUNC;
            ST_FUNC:    if (i_sts.out_free) n_state = ST_LEN;
            ST_LEN: begin
                if (i_sts.out_free) n_state = i_sts.pay_more ? ST_RD : ST_SUM;
            end
            ST_RD:      n_state = ST_PAY;
            ST_PAY: begin
                if (i_sts.out_free) n_state = i_sts.pay_more ? ST_RD : ST_SUM;
            end
            ST_SUM:     if (i_sts.out_free) n_state = ST_COLLECT;
            default:    n_state = ST_COLLECT;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        o_cmd.out_sel = SEL_HDR;
        unique case (r_state)
            ST_COLLECT: begin
                o_in_stall        = 1'b0;
                o_cmd.item_accept = i_in_valid;
            end
            ST_HDR: begin
                o_cmd.out_load = i_sts.out_free;
                o_cmd.out_sel  = SEL_HDR;
            end
            ST_FUNC: begin
                o_cmd.out_load = i_sts.out_free;
                o_cmd.out_sel  = SEL_FUNC;
            end
            ST_LEN: begin
                o_cmd.out_load = i_sts.out_free;
                o_cmd.out_sel  = SEL_LEN;
            end
            ST_RD: begin
                o_cmd.rd_issue = 1'b1;
            end
            ST_PAY: begin
                o_cmd.out_load = i_sts.out_free;
                o_cmd.out_sel  = SEL_PAY;
            end
            ST_SUM: begin
                o_cmd.out_load   = i_sts.out_free;
                o_cmd.out_sel    = SEL_SUM;
                o_cmd.frame_done = i_sts.out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    `LPFB_ASSERT_NXT(a_last_starts_emit, i_clk, i_rst_n,
        o_cmd.item_accept && i_payload_last, r_state == ST_HDR, "last item did not start frame")

endmodule

`default_nettype wire

[rtl/length_prefixed_frame_builder.sv]
// ----------------------------------------------------------------------------
// length_prefixed_frame_builder
// Collects payload bytes and sends a header/function/length/payload/sum frame.
// ----------------------------------------------------------------------------
// Collection takes one item per cycle. Once the item marked last is taken,
// input stalls while the frame goes out: the header, function code and
// length beats, then each payload beat as a buffer read followed by the
// output load, and last the checksum beat. The payload buffer's registered
// read port is why each payload beat needs the separate read step. Bytes
// past MAX_PAYLOAD are dropped and left out of the length and checksum.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefixed_frame_builder import lpfb_pkg::*; #(
    parameter int MAX_PAYLOAD = LPFB_MAX_PAYLOAD
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_payload_byte,
    input  wire logic       i_has_byte,
    input  wire logic [7:0] i_function_code,
    input  wire logic       i_payload_last,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_tx_byte,
    output logic            o_frame_last
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    lpfb_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_payload_last (i_payload_last),
        .i_sts          (sts),
        .o_cmd          (cmd),
        .o_in_stall     (o_in_stall)
    );

    lpfb_dp #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .i_payload_byte  (i_payload_byte),
        .i_has_byte      (i_has_byte),
        .i_function_code (i_function_code),
        .i_out_stall     (i_out_stall),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_out_valid     (o_out_valid),
        .o_tx_byte       (o_tx_byte),
        .o_frame_last    (o_frame_last)
    );

endmodule

`default_nettype wire
